[sv/rmt_pkg.sv]
// Shared types, command codes and constants for the regret matching table.
`timescale 1ns / 1ps
`default_nettype none
package rmt_pkg;

    // Command codes carried on tuser
    typedef enum logic [1:0] {
        CMD_ADD_REGRET = 2'd0,
        CMD_ADD_WEIGHT = 2'd1,
        CMD_READ_CUR   = 2'd2,
        CMD_READ_AVG   = 2'd3
    } cmd_t;

    localparam int SET_W    = 12;
    localparam int ACT_W    = 4;
    localparam int CNT_W    = 5;
    localparam int VAL_W    = 32;
    localparam int REGRET_W = 32;
    localparam int WEIGHT_W = 48;
    localparam int SUM_W    = 52;   // up to 16 weights of 48 bits
    localparam int REM_W    = 53;
    localparam int PROB_W   = 17;
    localparam int QSTEPS   = 17;
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 24;

    // Classified request passed from front to back
    typedef struct packed {
        cmd_t                     cmd;
        logic                     set_ok;
        logic [SET_W-1:0]         set_index;
        logic [ACT_W-1:0]         action_index;
        logic [CNT_W-1:0]         count;      // already clamped to 1..read max
        logic signed [VAL_W-1:0]  value;
    } item_t;

    // Uniform probability 65536 / n for n in 1..16
    function automatic logic [PROB_W-1:0] uniform_q16(input logic [CNT_W-1:0] n);
        logic [PROB_W-1:0] p;
        case (n)
            5'd1:    p = 17'd65536;
            5'd2:    p = 17'd32768;
            5'd3:    p = 17'd21845;
            5'd4:    p = 17'd16384;
            5'd5:    p = 17'd13107;
            5'd6:    p = 17'd10922;
            5'd7:    p = 17'd9362;
            5'd8:    p = 17'd8192;
            5'd9:    p = 17'd7281;
            5'd10:   p = 17'd6553;
            5'd11:   p = 17'd5957;
            5'd12:   p = 17'd5461;
            5'd13:   p = 17'd5041;
            5'd14:   p = 17'd4681;
            5'd15:   p = 17'd4369;
            5'd16:   p = 17'd4096;
            default: p = 17'd65536;
        endcase
        return p;
    endfunction

endpackage
`default_nettype wire

[sv/rmt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module rmt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[sv/rmt_front.sv]
// Front end: accepts requests, clamps and classifies them, queues them for the back end.
`timescale 1ns / 1ps
`default_nettype none
module rmt_front #(
    parameter int SET_COUNT   = 4096,
    parameter int ACTIONS_MAX = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [rmt_pkg::IN_DATA_W-1:0] s_tdata,
    input  wire logic [1:0]                  s_tuser,
    input  wire logic                        clear_done,
    output logic                             item_valid,
    input  wire logic                        item_ready,
    output rmt_pkg::item_t                   item
);
    import rmt_pkg::*;

    localparam int READ_MAX = (ACTIONS_MAX < 16) ? ACTIONS_MAX : 16;

    item_t            fifo_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       cnt_reg, cnt_next;

    logic             push, pop, drop;
    item_t            cls;
    logic [CNT_W-1:0] cnt_in;
    logic [ACT_W-1:0] act_in;

    // Classify the incoming request
    always_comb
    begin
        act_in = s_tdata[15:12];
        cnt_in = s_tdata[20:16];
        cls.set_index    = s_tdata[11:0];
        cls.action_index = act_in;
        cls.value        = s_tdata[52:21];
        cls.set_ok       = (32'(cls.set_index) < 32'(SET_COUNT));
        case (s_tuser)
            CMD_ADD_REGRET: cls.cmd = CMD_ADD_REGRET;
            CMD_ADD_WEIGHT: cls.cmd = CMD_ADD_WEIGHT;
            CMD_READ_CUR:   cls.cmd = CMD_READ_CUR;
            default:        cls.cmd = CMD_READ_AVG;
        endcase
        if (cnt_in == '0)
            cls.count = 5'd1;
        else if (32'(cnt_in) > 32'(READ_MAX))
            cls.count = CNT_W'(READ_MAX);
        else
            cls.count = cnt_in;
        // updates outside the table are accepted and dropped
        drop = (cls.cmd == CMD_ADD_REGRET || cls.cmd == CMD_ADD_WEIGHT) &&
               (!cls.set_ok || 32'(act_in) >= 32'(ACTIONS_MAX));
    end

    assign s_tready   = clear_done && (cnt_reg != 2'd2);
    assign push       = s_tvalid && s_tready && !drop;
    assign item_valid = (cnt_reg != 2'd0);
    assign pop        = item_valid && item_ready;
    assign item       = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    // Queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= cls;
        end
    end
endmodule
`default_nettype wire

[sv/rmt_back.sv]
// Back end: clearing pass, read-modify-write updates, sums and serial division for reads.
`timescale 1ns / 1ps
`default_nettype none
module rmt_back #(
    parameter int SET_COUNT   = 4096,
    parameter int ACTIONS_MAX = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    output logic                             clear_done,
    input  wire logic                        item_valid,
    output logic                             item_ready,
    input  wire rmt_pkg::item_t              item,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [rmt_pkg::ACT_W-1:0]        out_slot,
    output logic [rmt_pkg::PROB_W-1:0]       out_prob,
    output logic                             out_last
);
    import rmt_pkg::*;

    localparam int DEPTH = SET_COUNT * ACTIONS_MAX;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_UPD_RD, ST_UPD_WR, ST_SUM_RD, ST_SUM_ACC,
        ST_DIV_RD, ST_DIV_LD, ST_DIV_STEP, ST_EMIT
    } state_t;

    state_t              state_reg;
    item_t               cur_reg;
    logic [ACT_W-1:0]    idx_reg;
    logic [AW-1:0]       clr_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [PROB_W-1:0]   q_reg;
    logic [4:0]          step_reg;
    logic                out_valid_reg;
    logic [ACT_W-1:0]    out_slot_reg;
    logic [PROB_W-1:0]   out_prob_reg;
    logic                out_last_reg;

    logic                  r_we, w_we;
    logic [AW-1:0]         waddr, raddr;
    logic [REGRET_W-1:0]   r_wdata, r_rdata;
    logic [WEIGHT_W-1:0]   w_wdata, w_rdata;
    logic [ACT_W-1:0]      addr_act;
    logic [31:0]           addr_full;
    logic [WEIGHT_W-1:0]   v;
    logic signed [33:0]    r_sum;
    logic [WEIGHT_W:0]     w_sum;
    logic                  weight_pos;
    logic [REM_W-1:0]      rem_sub;
    logic                  rem_ge;
    logic                  out_free;
    logic                  is_last;

    rmt_ram #(.WIDTH(REGRET_W), .DEPTH(DEPTH)) u_regret (
        .clk(clk), .we(r_we), .waddr(waddr), .wdata(r_wdata),
        .raddr(raddr), .rdata(r_rdata)
    );

    rmt_ram #(.WIDTH(WEIGHT_W), .DEPTH(DEPTH)) u_weight (
        .clk(clk), .we(w_we), .waddr(waddr), .wdata(w_wdata),
        .raddr(raddr), .rdata(w_rdata)
    );

    // Address of the entry in use
    always_comb
    begin
        addr_act  = (state_reg == ST_UPD_RD || state_reg == ST_UPD_WR) ?
                    cur_reg.action_index : idx_reg;
        addr_full = 32'(cur_reg.set_index) * 32'(ACTIONS_MAX) + 32'(addr_act);
        raddr     = addr_full[AW-1:0];
    end

    // Update arithmetic and write port
    always_comb
    begin
        r_sum = $signed({2'b00, r_rdata}) + 34'(cur_reg.value);
        weight_pos = !cur_reg.value[VAL_W-1] && (cur_reg.value != '0);
        w_sum = {1'b0, w_rdata} + {17'd0, cur_reg.value};
        r_we = 1'b0;
        w_we = 1'b0;
        waddr = raddr;
        if (r_sum < 0)
            r_wdata = '0;
        else if (r_sum[33:32] != 2'b00)
            r_wdata = '1;
        else
            r_wdata = r_sum[31:0];
        w_wdata = w_sum[WEIGHT_W] ? '1 : w_sum[WEIGHT_W-1:0];
        if (state_reg == ST_CLEAR)
        begin
            r_we    = 1'b1;
            w_we    = 1'b1;
            waddr   = clr_reg;
            r_wdata = '0;
            w_wdata = '0;
        end
        else if (state_reg == ST_UPD_WR)
        begin
            r_we = (cur_reg.cmd == CMD_ADD_REGRET);
            w_we = (cur_reg.cmd == CMD_ADD_WEIGHT) && weight_pos;
        end
    end

    // Entry value for reads, zero for sets beyond the table
    always_comb
    begin
        if (!cur_reg.set_ok)
            v = '0;
        else if (cur_reg.cmd == CMD_READ_AVG)
            v = w_rdata;
        else
            v = {16'd0, r_rdata};
        rem_ge  = (rem_reg >= {1'b0, sum_reg});
        rem_sub = rem_reg - {1'b0, sum_reg};
    end

    assign out_free   = !out_valid_reg || out_ready;
    assign is_last    = ({1'b0, idx_reg} + 5'd1 == cur_reg.count);
    assign clear_done = (state_reg != ST_CLEAR);
    assign item_ready = (state_reg == ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign out_slot   = out_slot_reg;
    assign out_prob   = out_prob_reg;
    assign out_last   = out_last_reg;

    // Sequencer, divider and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cur_reg       <= '0;
            clr_reg       <= '0;
            sum_reg       <= '0;
            rem_reg       <= '0;
            q_reg         <= '0;
            out_valid_reg <= 1'b0;
            out_slot_reg  <= '0;
            out_prob_reg  <= '0;
            out_last_reg  <= 1'b0;
            idx_reg       <= '0;
            step_reg      <= '0;
        end
        else
        begin
            // a new result in ST_EMIT takes over the output register
            if (out_valid_reg && out_ready && state_reg != ST_EMIT)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == AW'(DEPTH - 1))
                        state_reg <= ST_IDLE;
                end
                ST_IDLE:
                begin
                    if (item_valid)
                    begin
                        cur_reg <= item;
                        idx_reg <= '0;
                        sum_reg <= '0;
                        if (item.cmd == CMD_ADD_REGRET || item.cmd == CMD_ADD_WEIGHT)
                            state_reg <= ST_UPD_RD;
                        else
                            state_reg <= ST_SUM_RD;
                    end
                end
                ST_UPD_RD:   state_reg <= ST_UPD_WR;
                ST_UPD_WR:   state_reg <= ST_IDLE;
                ST_SUM_RD:   state_reg <= ST_SUM_ACC;
                ST_SUM_ACC:
                begin
                    sum_reg <= sum_reg + SUM_W'(v);
                    if (is_last)
                    begin
                        idx_reg   <= '0;
                        state_reg <= ST_DIV_RD;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= ST_SUM_RD;
                    end
                end
                ST_DIV_RD:   state_reg <= ST_DIV_LD;
                ST_DIV_LD:
                begin
                    rem_reg  <= REM_W'(v);
                    step_reg <= 5'(QSTEPS - 1);
                    if (sum_reg == '0)
                    begin
                        q_reg     <= uniform_q16(cur_reg.count);
                        state_reg <= ST_EMIT;
                    end
                    else
                    begin
                        q_reg     <= '0;
                        state_reg <= ST_DIV_STEP;
                    end
                end
                ST_DIV_STEP:
                begin
                    // one quotient bit per cycle, remainder stays below twice the sum
                    q_reg <= {q_reg[PROB_W-2:0], rem_ge};
                    if (rem_ge)
                        rem_reg <= {rem_sub[REM_W-2:0], 1'b0};
                    else
                        rem_reg <= {rem_reg[REM_W-2:0], 1'b0};
                    step_reg <= step_reg - 1'b1;
                    if (step_reg == '0)
                        state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_slot_reg  <= idx_reg;
                        out_prob_reg  <= q_reg;
                        out_last_reg  <= is_last;
                        if (is_last)
                            state_reg <= ST_IDLE;
                        else
                        begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= ST_DIV_RD;
                        end
                    end
                end
                default:     state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

[sv/regret_matching_table.sv]
// Top level of the regret matching table: front queue, back engine, stream ports.
// Updates pass through the back-end pick-up, read and write; dropped updates never reach it.
// A read of n actions is picked up, each action read and summed, then per action divided
// bit-serially and emitted (uniform answers skip the division); output stalls hold the emit.
// The two-entry queue accepts requests while the back end works.
// After reset a clearing pass zeroes every entry of both stores; tready stays low.
`timescale 1ns / 1ps
`default_nettype none
module regret_matching_table #(
    parameter int SET_COUNT   = 4096,
    parameter int ACTIONS_MAX = 16
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // set_index, action_index, action_count, value
    input  wire logic [rmt_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    input  wire logic [1:0]                       s_axis_tuser,  // command
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    output logic [rmt_pkg::OUT_DATA_W-1:0]        m_axis_tdata,  // slot, probability
    output logic                                  m_axis_tlast
);
    import rmt_pkg::*;

    logic                clear_done;
    logic                item_valid, item_ready;
    item_t               item;
    logic [ACT_W-1:0]    out_slot;
    logic [PROB_W-1:0]   out_prob;

    rmt_front #(.SET_COUNT(SET_COUNT), .ACTIONS_MAX(ACTIONS_MAX)) u_front (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_axis_tvalid), .s_tready(s_axis_tready),
        .s_tdata(s_axis_tdata), .s_tuser(s_axis_tuser),
        .clear_done(clear_done),
        .item_valid(item_valid), .item_ready(item_ready), .item(item)
    );

    rmt_back #(.SET_COUNT(SET_COUNT), .ACTIONS_MAX(ACTIONS_MAX)) u_back (
        .clk(clk), .rst_n(rst_n), .clear_done(clear_done),
        .item_valid(item_valid), .item_ready(item_ready), .item(item),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_slot(out_slot), .out_prob(out_prob), .out_last(m_axis_tlast)
    );

    // Pack result fields, slot in the low bits
    assign m_axis_tdata = {3'd0, out_prob, out_slot};
endmodule
`default_nettype wire
